// File: rtl/wmpc_pkg.sv
// Shared constants for the window maximum point counter.
// No dependencies.
package wmpc_pkg;

    localparam int POS_W   = 32;  // point position, two's complement
    localparam int SPAN_W  = 31;  // span register
    localparam int THR_W   = POS_W + 1;  // exact position minus span
    localparam int OCNT_W  = 7;   // count fields on the result item
    localparam int S_DATA_W = POS_W;
    localparam int M_DATA_W = 16; // covered, best, overflow, zero pad

endpackage

// File: rtl/wmpc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies. Read data holds while no read is issued.
module wmpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/window_max_point_count.sv
// After accepting an input item the block evicts stored points below position - span
// (one RAM read per cycle while evicting), then, once the output register is free,
// stores the point and registers the result; no new item is accepted until then.
// Reset (aresetn, synchronous): empty window, maximum, overflow and span zero.
// Depends on wmpc_pkg and wmpc_ram.
module window_max_point_count #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wmpc_pkg::SPAN_W-1:0]    cfg_data,    // cord_span
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wmpc_pkg::S_DATA_W-1:0]  s_tdata,     // [31:0] position
    input  logic                           s_tuser,     // [0] first
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wmpc_pkg::M_DATA_W-1:0]  m_tdata      // [6:0] covered_now,
                                                        // [13:7] best_so_far,
                                                        // [14] overflow, [15] 0
);
    import wmpc_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT
    } state_t;

    state_t              state_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [IDX_W-1:0]    oldest_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    best_reg;
    logic                ovf_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic                in_acc;
    logic                out_free;
    logic [THR_W-1:0]    thr_in;
    logic [POS_W-1:0]    rd_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                below;
    logic                evict;
    logic                finish;
    logic [IDX_W-1:0]    oldest_nxt;
    logic                full;
    logic [IDX_W-1:0]    oldest_f;
    logic [CNT_W-1:0]    occ_f;
    logic [SUM_W-1:0]    slot_sum;
    logic [IDX_W-1:0]    wr_addr;
    logic [CNT_W-1:0]    occ_next;
    logic [CNT_W-1:0]    best_next;
    logic                ovf_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign thr_in = $signed({s_tdata[POS_W-1], s_tdata}) - $signed({2'b00, span_reg});

    assign oldest_nxt = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;

    assign below  = $signed({rd_data[POS_W-1], rd_data}) < $signed(thr_reg);
    assign evict  = (state_reg == ST_EVICT) && (occ_reg != '0) && below;
    assign finish = (state_reg == ST_EVICT) && !evict && out_free;

    // Store full after eviction: drop the oldest point
    assign full      = (occ_reg == DEPTH_CNT);
    assign oldest_f  = full ? oldest_nxt : oldest_reg;
    assign occ_f     = full ? DEPTH_CNT - 1'b1 : occ_reg;
    assign slot_sum  = SUM_W'(oldest_f) + SUM_W'(occ_f);
    assign wr_addr   = (slot_sum >= DEPTH_SUM) ? IDX_W'(slot_sum - DEPTH_SUM)
                                               : IDX_W'(slot_sum);
    assign occ_next  = occ_f + 1'b1;
    assign best_next = (occ_next > best_reg) ? occ_next : best_reg;
    assign ovf_next  = ovf_reg | full;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = oldest_reg;
        if (in_acc) begin
            rd_en   = 1'b1;
            rd_addr = s_tuser ? '0 : oldest_reg;
        end else if (evict) begin
            rd_en   = 1'b1;
            rd_addr = oldest_nxt;
        end
    end

    wmpc_ram #(
        .WIDTH (POS_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (finish),
        .wr_addr (wr_addr),
        .wr_data (pos_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            span_reg    <= '0;
            oldest_reg  <= '0;
            occ_reg     <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                span_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        pos_reg   <= s_tdata;
                        thr_reg   <= thr_in;
                        state_reg <= ST_EVICT;
                        if (s_tuser) begin
                            oldest_reg <= '0;
                            occ_reg    <= '0;
                            best_reg   <= '0;
                            ovf_reg    <= 1'b0;
                        end
                    end
                end
                ST_EVICT: begin
                    if (evict) begin
                        oldest_reg <= oldest_nxt;
                        occ_reg    <= occ_reg - 1'b1;
                    end else if (finish) begin
                        oldest_reg  <= oldest_f;
                        occ_reg     <= occ_next;
                        best_reg    <= best_next;
                        ovf_reg     <= ovf_next;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, ovf_next, OCNT_W'(best_next),
                                        OCNT_W'(occ_next)};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/window_count_checker.sv
// Checker for window_max_point_count: watches the span, point and result channels,
// predicts covered/best/overflow per point and compares in order.
// Depends on wmpc_pkg.
module window_count_checker #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wmpc_pkg::SPAN_W-1:0]    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [wmpc_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [wmpc_pkg::M_DATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             outstanding
);
    import wmpc_pkg::*;

    typedef struct packed {
        logic              pad;
        logic              overflow;
        logic [OCNT_W-1:0] best_so_far;
        logic [OCNT_W-1:0] covered_now;
    } count_result_t;

    longint          held_pos [DEPTH];
    int unsigned     head_slot;
    int unsigned     held_count;
    int unsigned     best_count;
    logic            sticky_ovf;
    logic [SPAN_W-1:0] span;
    count_result_t   expected_counts[$];

    // Evicts below position - span (exact, 33-bit range), drops the oldest when full.
    function automatic count_result_t take_point(input logic signed [POS_W-1:0] pos,
                                                 input logic start_set);
        longint        thr;
        count_result_t r;
        thr = longint'(pos) - longint'(span);
        if (start_set) begin
            head_slot  = 0;
            held_count = 0;
            best_count = 0;
            sticky_ovf = 1'b0;
        end
        while (held_count > 0 && held_pos[head_slot] < thr) begin
            head_slot  = (head_slot + 1) % DEPTH;
            held_count = held_count - 1;
        end
        if (held_count >= DEPTH) begin
            head_slot  = (head_slot + 1) % DEPTH;
            held_count = DEPTH - 1;
            sticky_ovf = 1'b1;
        end
        held_pos[(head_slot + held_count) % DEPTH] = longint'(pos);
        held_count = held_count + 1;
        if (held_count > best_count)
            best_count = held_count;
        r.covered_now = held_count[OCNT_W-1:0];
        r.best_so_far = best_count[OCNT_W-1:0];
        r.overflow    = sticky_ovf;
        r.pad         = 1'b0;
        return r;
    endfunction

    function automatic void report(input string what, input count_result_t exp_r,
                                   input count_result_t got);
        if (fail_count < 10) begin
            $write("%0t: %s mismatch: expected covered=%0d best=%0d ovf=%0d pad=%0d,",
                   $realtime, what, exp_r.covered_now, exp_r.best_so_far, exp_r.overflow,
                   exp_r.pad);
            $display(" got covered=%0d best=%0d ovf=%0d pad=%0d",
                     got.covered_now, got.best_so_far, got.overflow, got.pad);
        end
        fail_count = fail_count + 1;
    endfunction

    always @(posedge aclk) begin
        count_result_t got;
        count_result_t exp_r;
        if (!aresetn) begin
            head_slot  = 0;
            held_count = 0;
            best_count = 0;
            sticky_ovf = 1'b0;
            span       = '0;
            expected_counts.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                span = cfg_data;
            if (s_tvalid && s_tready)
                expected_counts.push_back(take_point(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_counts.size() == 0) begin
                    exp_r = '0;
                    report("unexpected item", exp_r, got);
                end else begin
                    exp_r = expected_counts.pop_front();
                    if (got.covered_now != exp_r.covered_now)
                        report("covered_now", exp_r, got);
                    else if (got.best_so_far != exp_r.best_so_far)
                        report("best_so_far", exp_r, got);
                    else if (got.overflow != exp_r.overflow)
                        report("overflow", exp_r, got);
                    else if (got.pad != exp_r.pad)
                        report("padding", exp_r, got);
                end
            end
        end
        outstanding = expected_counts.size();
    end

endmodule

// File: dv/tb_window_max_point_count.sv
// Top of the window_max_point_count testbench: clock, reset, span writes, point
// stimulus with idling and back-pressure, watchdog and verdict.
// Depends on wmpc_pkg, window_max_point_count and window_count_checker.
module tb_window_max_point_count;
    import wmpc_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SPAN_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;     // [31:0] position
    logic                 s_tuser   = 1'b0;   // [0] first
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;            // [6:0] covered, [13:7] best, [14] ovf, [15] 0

    int  fail_count;
    int  outstanding;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_req     = 1'b0;
    logic [SPAN_W-1:0] span_now = '0;

    window_max_point_count #(.WINDOW_DEPTH(64)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    window_count_checker #(.DEPTH(64)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        static int  hold_left = 0;
        static bit  hold_done = 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        static int quiet = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_span(input logic [SPAN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        span_now = value;
    endtask

    task automatic send_point(input logic signed [POS_W-1:0] pos, input logic start_set);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        s_tuser  <= start_set;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly sorted sets with random content; some noise and out-of-order points.
    task automatic run_sets(input int n_items);
        int          sent;
        int          len;
        int unsigned step_max;
        longint      cur;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                send_point($urandom, 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 24);
                case ($urandom_range(0, 4))
                    0: step_max = 0;
                    1: step_max = $urandom_range(1, 3);
                    2: step_max = span_now / 4 + 1;
                    3: step_max = $urandom_range(0, 1 << 20);
                    default: step_max = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0: cur = -64'sd2147483648 + $urandom_range(0, 1000);
                    1: cur = 64'sd2147483647 - $urandom_range(0, 1000);
                    default: cur = longint'($signed($urandom));
                endcase
                for (int i = 0; i < len; i++) begin
                    if (i > 0)
                        cur = cur + $urandom_range(0, step_max);
                    if (cur > 64'sd2147483647)
                        cur = 64'sd2147483647;
                    if (i > 0 && $urandom_range(0, 29) == 0)
                        send_point(POS_W'(cur - $urandom_range(1, 1 << 16)), 1'b0);
                    else
                        send_point(POS_W'(cur), (i == 0) && ($urandom_range(0, 9) != 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [SPAN_W-1:0] phase_span [6];
        phase_span[0] = {SPAN_W{1'b1}};
        phase_span[1] = '0;
        phase_span[2] = 31'd1000;
        phase_span[3] = SPAN_W'($urandom);
        phase_span[4] = 31'd16;
        phase_span[5] = {SPAN_W{1'b1}};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, exact threshold near the bottom, out-of-order point.
        send_idle_pct = 33;
        recv_idle_pct <= 54;
        write_span(31'd5);
        send_point(32'sh8000_0000, 1'b1);
        send_point(32'sh8000_0000, 1'b0);
        send_point(32'sh8000_0005, 1'b0);
        send_point(32'sh8000_0006, 1'b0);
        send_point(32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh7FFF_FFFF, 1'b0);
        send_point(32'sd0, 1'b0);
        send_point(32'sd0, 1'b1);
        send_point(32'sd5, 1'b0);
        send_point(32'sd11, 1'b0);
        send_point(32'sd11, 1'b0);
        send_point(-32'sd1, 1'b0);
        drain();
        write_span({SPAN_W{1'b1}});
        send_point(32'sh8000_0000, 1'b1);
        send_point(-32'sd1, 1'b0);
        send_point(32'sd0, 1'b0);
        send_point(32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh5555_5555, 1'b1);
        send_point(32'sh5555_5555, 1'b0);
        send_point(32'shAAAA_AAAA, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 33;
                recv_idle_pct <= 54;
            end else if (ph < 4) begin
                send_idle_pct = 54;
                recv_idle_pct <= 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            write_span(phase_span[ph]);
            if (ph == 1)
                hold_req <= 1'b1;
            run_sets(310);
            drain();
        end

        repeat (80) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/wmpc_pkg.sv
rtl/wmpc_ram.sv
rtl/window_max_point_count.sv
dv/window_count_checker.sv
dv/tb_window_max_point_count.sv
